// ===== sv/lpps_pkg.sv =====
`timescale 1ns / 1ps
package lpps_pkg;

  localparam int LINE_PIXELS_DEF     = 32;
  localparam int POSITION_WEIGHT_DEF = 10;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 12;
  localparam int NEED_W     = 13;
  localparam int ERR_W      = 12;
  localparam int CHG_W      = 13;
  localparam int SPD_W      = 9;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_Q8        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_RATE_Q8   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT_THR   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_BURST = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_LIMIT  = 3'd5;

  localparam logic [7:0]  BASE_SPEED_RST   = 8'd40;
  localparam logic [9:0]  KP_Q8_RST        = 10'd51;
  localparam logic [15:0] KD_RATE_Q8_RST   = 16'd5120;
  localparam logic [7:0]  BRIGHT_THR_RST   = 8'd127;
  localparam logic [4:0]  FRAMES_BURST_RST = 5'd10;
  localparam logic [7:0]  SPEED_LIMIT_RST  = 8'd255;

  typedef struct packed {
    logic [7:0]  base_speed;
    logic [9:0]  kp_q8;
    logic [15:0] kd_rate_q8;
    logic [7:0]  brightness_threshold;
    logic [4:0]  frames_per_burst;
    logic [7:0]  speed_limit;
  } cfg_t;

  // Hand-off from the accumulating front end into the snapshot buffer.
  typedef struct packed {
    logic              load;
    logic              period;
    logic [NEED_W-1:0] need;
  } snap_ctl_t;

endpackage

// ===== sv/lpps_front.sv =====
`timescale 1ns / 1ps
module lpps_front #(
  parameter int LINE_PIXELS = lpps_pkg::LINE_PIXELS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  input  logic [lpps_pkg::IN_DATA_W-1:0]                   in_tdata,
  input  lpps_pkg::cfg_t                                   cfg,
  input  logic                                             snap_full,
  input  logic                                             snap_release,
  output lpps_pkg::snap_ctl_t                              snap_ctl,
  output logic [LINE_PIXELS-1:0][lpps_pkg::SUM_W-1:0]      snap_data
);

  localparam int POS_W = $clog2(LINE_PIXELS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_PIXELS - 1);

  logic [POS_W-1:0]                             pos_r, pos_nxt;
  logic [3:0]                                   fc_r, fc_nxt;
  logic [LINE_PIXELS-1:0][lpps_pkg::SUM_W-1:0]  sums_r, sums_nxt;
  logic [4:0]                                   frames_eff;
  logic                                         line_end;
  logic                                         burst_end;
  logic                                         in_acc;
  logic [lpps_pkg::PIX_W-1:0]                   pixel;
  logic [lpps_pkg::SUM_W-1:0]                   sum_upd;

  assign pixel = in_tdata[lpps_pkg::PIX_W-1:0];

  always_comb begin
    if (cfg.frames_per_burst == 5'd0) begin
      frames_eff = 5'd1;
    end else if (cfg.frames_per_burst > 5'd16) begin
      frames_eff = 5'd16;
    end else begin
      frames_eff = cfg.frames_per_burst;
    end
  end

  assign line_end  = (pos_r == POS_LAST);
  assign burst_end = line_end && ((5'(fc_r) + 5'd1) >= frames_eff);

  // Only the pixel that closes a burst needs room in the snapshot buffer.
  assign in_tready = !burst_end || !snap_full || snap_release;
  assign in_acc    = in_tvalid && in_tready;
  assign sum_upd   = sums_r[pos_r] + lpps_pkg::SUM_W'(pixel);

  always_comb begin
    sums_nxt = sums_r;
    pos_nxt  = pos_r;
    fc_nxt   = fc_r;
    snap_data = sums_r;
    snap_data[pos_r] = sum_upd;
    snap_ctl.load   = in_acc && burst_end;
    snap_ctl.period = in_tdata[lpps_pkg::PIX_W];
    snap_ctl.need   = (lpps_pkg::NEED_W'(cfg.brightness_threshold) + lpps_pkg::NEED_W'(1))
                      * lpps_pkg::NEED_W'(frames_eff);
    if (in_acc) begin
      sums_nxt[pos_r] = sum_upd;
      if (line_end) begin
        pos_nxt = '0;
        if (burst_end) begin
          fc_nxt   = '0;
          sums_nxt = '0;
        end else begin
          fc_nxt = fc_r + 4'd1;
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fc_r   <= '0;
      sums_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fc_r   <= fc_nxt;
      sums_r <= sums_nxt;
    end
  end

  a_burst_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && burst_end) |=> (pos_r == '0 && fc_r == '0 && sums_r == '0))
    else $error("burst end did not clear the accumulation state");

  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !line_end) |=> (fc_r == $past(fc_r)))
    else $error("frame count moved inside a line");

endmodule

// ===== sv/lpps_snap.sv =====
`timescale 1ns / 1ps
module lpps_snap #(
  parameter int LINE_PIXELS = lpps_pkg::LINE_PIXELS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  lpps_pkg::snap_ctl_t                          snap_ctl,
  input  logic [LINE_PIXELS-1:0][lpps_pkg::SUM_W-1:0]  snap_data,
  input  logic                                         snap_release,
  input  logic [$clog2(LINE_PIXELS)-1:0]               rd_idx,
  output logic                                         snap_full,
  output logic [lpps_pkg::SUM_W-1:0]                   rd_data,
  output logic [lpps_pkg::NEED_W-1:0]                  snap_need,
  output logic                                         snap_period
);

  logic                                         full_r;
  logic [LINE_PIXELS-1:0][lpps_pkg::SUM_W-1:0]  data_r;
  logic [lpps_pkg::NEED_W-1:0]                  need_r;
  logic                                         period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= (full_r && !snap_release) || snap_ctl.load;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ctl.load) begin
      data_r   <= snap_data;
      need_r   <= snap_ctl.need;
      period_r <= snap_ctl.period;
    end
  end

  assign snap_full   = full_r;
  assign rd_data     = data_r[rd_idx];
  assign snap_need   = need_r;
  assign snap_period = period_r;

endmodule

// ===== sv/lpps_back.sv =====
`timescale 1ns / 1ps
module lpps_back #(
  parameter int LINE_PIXELS     = lpps_pkg::LINE_PIXELS_DEF,
  parameter int POSITION_WEIGHT = lpps_pkg::POSITION_WEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpps_pkg::cfg_t                      cfg,
  input  logic                                snap_full,
  input  logic [lpps_pkg::SUM_W-1:0]          rd_data,
  input  logic [lpps_pkg::NEED_W-1:0]         snap_need,
  input  logic                                snap_period,
  output logic [$clog2(LINE_PIXELS)-1:0]      rd_idx,
  output logic                                snap_release,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpps_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int POS_W = $clog2(LINE_PIXELS);
  localparam int HALF  = LINE_PIXELS / 2;
  localparam int WGT_W = $clog2(POSITION_WEIGHT * HALF + 1) + 1;
  localparam int ACC_W = $clog2(POSITION_WEIGHT * HALF * (HALF + 1) / 2 + 1) + 2;

  localparam logic [POS_W-1:0]        IDX_LAST = POS_W'(LINE_PIXELS - 1);
  localparam logic signed [WGT_W-1:0] WGT_INIT = WGT_W'(-(POSITION_WEIGHT * HALF));
  localparam logic signed [WGT_W-1:0] WGT_STEP = WGT_W'(POSITION_WEIGHT);
  localparam logic signed [ACC_W-1:0] ERR_MAX  = ACC_W'(2047);
  localparam logic signed [ACC_W-1:0] ERR_MIN  = ACC_W'(-2048);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_UPD  = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_OUT  = 2'd3;

  // Scan over the snapshot, one position per cycle while it is full and not held at the last one.
  logic [POS_W-1:0]        idx_r;
  logic signed [ACC_W-1:0] acc_r, acc_add, wgt_ext;
  logic signed [WGT_W-1:0] wgt_r;
  logic                    hit;
  logic                    scan_adv;

  // Finishing sequence: error update, products, drive formation.
  logic [1:0]                              fin_state_r;
  logic signed [ACC_W-1:0]                 fin_acc_r;
  logic                                    fin_period_r;
  logic signed [lpps_pkg::ERR_W-1:0]       err_r, err_cl, prev_r;
  logic signed [lpps_pkg::CHG_W-1:0]       chg_r;
  logic signed [22:0]                      p_kp_r;
  logic signed [29:0]                      p_kd_r;
  logic signed [31:0]                      kp_ext, kd_ext, pd, base_q8, num_l, num_r;
  logic                                    out_load;
  logic                                    out_tvalid_r;
  logic [lpps_pkg::SPD_W-1:0]              left_r, right_r;
  logic [lpps_pkg::ERR_W-1:0]              out_err_r;

  function automatic logic [lpps_pkg::SPD_W-1:0] drive(input logic signed [31:0] num,
                                                       input logic [7:0] lim);
    logic signed [23:0] q;
    logic signed [23:0] lim_s;
    q = 24'(num >>> 8);
    // Shift floors; step back toward zero for negative values with a fraction.
    if (num[31] && (num[7:0] != 8'h00)) begin
      q = q + 24'sd1;
    end
    lim_s = {16'h0000, lim};
    if (q > lim_s) begin
      drive = lim_s[lpps_pkg::SPD_W-1:0];
    end else if (q < -lim_s) begin
      drive = lpps_pkg::SPD_W'(-lim_s);
    end else begin
      drive = q[lpps_pkg::SPD_W-1:0];
    end
  endfunction

  assign rd_idx  = idx_r;
  assign hit     = (lpps_pkg::NEED_W'(rd_data) >= snap_need);
  assign wgt_ext = ACC_W'(wgt_r);

  always_comb begin
    if (hit) begin
      acc_add = acc_r + wgt_ext;
    end else begin
      acc_add = acc_r;
    end
  end

  // The last position may only retire when the finishing side can take the sum.
  assign scan_adv     = snap_full && ((idx_r != IDX_LAST) || (fin_state_r == F_IDLE));
  assign snap_release = snap_full && (idx_r == IDX_LAST) && (fin_state_r == F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      acc_r <= '0;
      wgt_r <= WGT_INIT;
    end else if (scan_adv) begin
      if (idx_r == IDX_LAST) begin
        idx_r <= '0;
        acc_r <= '0;
        wgt_r <= WGT_INIT;
      end else begin
        idx_r <= idx_r + POS_W'(1);
        acc_r <= acc_add;
        wgt_r <= wgt_r + WGT_STEP;
      end
    end
  end

  always_comb begin
    if (fin_acc_r > ERR_MAX) begin
      err_cl = 12'sd2047;
    end else if (fin_acc_r < ERR_MIN) begin
      err_cl = -12'sd2048;
    end else begin
      err_cl = fin_acc_r[lpps_pkg::ERR_W-1:0];
    end
  end

  always_comb begin
    kp_ext  = p_kp_r;
    kd_ext  = p_kd_r;
    pd      = kp_ext + kd_ext;
    base_q8 = {16'h0000, cfg.base_speed, 8'h00};
    num_l   = base_q8 + pd;
    num_r   = base_q8 - pd;
  end

  assign out_load = (fin_state_r == F_OUT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_state_r <= F_IDLE;
      prev_r      <= '0;
      chg_r       <= '0;
    end else begin
      case (fin_state_r)
        F_IDLE: begin
          if (snap_release) begin
            fin_state_r <= F_UPD;
          end
        end
        F_UPD: begin
          // Difference of two 12-bit values always fits the 13-bit change.
          if (fin_period_r) begin
            chg_r  <= lpps_pkg::CHG_W'(err_cl) - lpps_pkg::CHG_W'(prev_r);
            prev_r <= err_cl;
          end
          fin_state_r <= F_MUL;
        end
        F_MUL: begin
          fin_state_r <= F_OUT;
        end
        F_OUT: begin
          if (out_load) begin
            fin_state_r <= F_IDLE;
          end
        end
        default: begin
          fin_state_r <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (snap_release) begin
      fin_acc_r    <= acc_add;
      fin_period_r <= snap_period;
    end
    if (fin_state_r == F_UPD) begin
      err_r <= err_cl;
    end
    if (fin_state_r == F_MUL) begin
      p_kp_r <= $signed({1'b0, cfg.kp_q8}) * err_r;
      p_kd_r <= $signed({1'b0, cfg.kd_rate_q8}) * chg_r;
    end
    if (out_load) begin
      left_r    <= drive(num_l, cfg.speed_limit);
      right_r   <= drive(num_r, cfg.speed_limit);
      out_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_err_r, right_r, left_r};

  a_prev_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_state_r == F_UPD && fin_period_r) |=> (prev_r == err_r))
    else $error("previous error not updated with the burst error");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(fin_state_r == F_OUT))
    else $error("result raised outside the output step");

  a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
    snap_release |=> (idx_r == '0 && acc_r == '0 && wgt_r == WGT_INIT))
    else $error("scan did not restart after releasing the snapshot");

endmodule

// ===== sv/line_position_pd_steering_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  in_tdata:  pixel[7:0], period_elapsed[8]
// out_      master     out_tvalid/out_tready out_tdata: left_speed[8:0], right_speed[17:9],
//                                              line_error[29:18]
// cfg_      write      cfg_we               cfg_addr register index, cfg_wdata value
//
// One pixel is taken every clock unless the block stalls. A burst's result is formed
// after its last pixel: the snapshot of the sums is scanned one position per cycle,
// then the error update, the gain products and the drive saturation follow in turn.
// Only the pixel that closes a burst can stall, while the previous burst's snapshot is
// still being scanned or its result is held by out_tready low.
// Reset is synchronous: sums, counters, the previous error and the change clear, registers take their defaults.
module line_position_pd_steering_core #(
  parameter int LINE_PIXELS     = lpps_pkg::LINE_PIXELS_DEF,
  parameter int POSITION_WEIGHT = lpps_pkg::POSITION_WEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpps_pkg::IN_DATA_W-1:0]      in_tdata,   // pixel, period_elapsed
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpps_pkg::OUT_DATA_W-1:0]     out_tdata,  // left_speed, right_speed, line_error
  input  logic                                cfg_we,
  input  logic [lpps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lpps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [7:0]  base_speed_r;
  logic [9:0]  kp_q8_r;
  logic [15:0] kd_rate_q8_r;
  logic [7:0]  bright_thr_r;
  logic [4:0]  frames_burst_r;
  logic [7:0]  speed_limit_r;

  lpps_pkg::cfg_t                              cfg;
  lpps_pkg::snap_ctl_t                         snap_ctl;
  logic [LINE_PIXELS-1:0][lpps_pkg::SUM_W-1:0] snap_data;
  logic                                        snap_full;
  logic                                        snap_release;
  logic [$clog2(LINE_PIXELS)-1:0]              rd_idx;
  logic [lpps_pkg::SUM_W-1:0]                  rd_data;
  logic [lpps_pkg::NEED_W-1:0]                 snap_need;
  logic                                        snap_period;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r   <= lpps_pkg::BASE_SPEED_RST;
      kp_q8_r        <= lpps_pkg::KP_Q8_RST;
      kd_rate_q8_r   <= lpps_pkg::KD_RATE_Q8_RST;
      bright_thr_r   <= lpps_pkg::BRIGHT_THR_RST;
      frames_burst_r <= lpps_pkg::FRAMES_BURST_RST;
      speed_limit_r  <= lpps_pkg::SPEED_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lpps_pkg::REG_BASE_SPEED:   base_speed_r   <= cfg_wdata[7:0];
        lpps_pkg::REG_KP_Q8:        kp_q8_r        <= cfg_wdata[9:0];
        lpps_pkg::REG_KD_RATE_Q8:   kd_rate_q8_r   <= cfg_wdata[15:0];
        lpps_pkg::REG_BRIGHT_THR:   bright_thr_r   <= cfg_wdata[7:0];
        lpps_pkg::REG_FRAMES_BURST: frames_burst_r <= cfg_wdata[4:0];
        lpps_pkg::REG_SPEED_LIMIT:  speed_limit_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.base_speed           = base_speed_r;
  assign cfg.kp_q8                = kp_q8_r;
  assign cfg.kd_rate_q8           = kd_rate_q8_r;
  assign cfg.brightness_threshold = bright_thr_r;
  assign cfg.frames_per_burst     = frames_burst_r;
  assign cfg.speed_limit          = speed_limit_r;

  lpps_front #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .cfg          (cfg),
    .snap_full    (snap_full),
    .snap_release (snap_release),
    .snap_ctl     (snap_ctl),
    .snap_data    (snap_data)
  );

  lpps_snap #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_snap (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_ctl     (snap_ctl),
    .snap_data    (snap_data),
    .snap_release (snap_release),
    .rd_idx       (rd_idx),
    .snap_full    (snap_full),
    .rd_data      (rd_data),
    .snap_need    (snap_need),
    .snap_period  (snap_period)
  );

  lpps_back #(
    .LINE_PIXELS     (LINE_PIXELS),
    .POSITION_WEIGHT (POSITION_WEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .snap_full    (snap_full),
    .rd_data      (rd_data),
    .snap_need    (snap_need),
    .snap_period  (snap_period),
    .rd_idx       (rd_idx),
    .snap_release (snap_release),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== dv/line_position_pd_steering_core_tb.sv =====
`timescale 1ns / 1ps
module line_position_pd_steering_core_tb;

  localparam int LINE_PX     = lpps_pkg::LINE_PIXELS_DEF;
  localparam int WEIGHT      = lpps_pkg::POSITION_WEIGHT_DEF;
  localparam int TOTAL_ITEMS = 1750;

  localparam int PIX_W      = lpps_pkg::PIX_W;
  localparam int SUM_W      = lpps_pkg::SUM_W;
  localparam int ERR_W      = lpps_pkg::ERR_W;
  localparam int SPD_W      = lpps_pkg::SPD_W;
  localparam int IN_DATA_W  = lpps_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = lpps_pkg::OUT_DATA_W;
  localparam int CFG_ADDR_W = lpps_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = lpps_pkg::CFG_DATA_W;

  // Indexes past the end of the register list; writes to them must be dropped.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum int {FK_FIXED, FK_LINE, FK_NOISE, FK_NEAR_THR, FK_EXTREMES} frame_kind_t;
  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM} stall_style_t;

  typedef struct {
    logic signed [SPD_W-1:0] left_spd;
    logic signed [SPD_W-1:0] right_spd;
    logic signed [ERR_W-1:0] line_err;
  } steer_out_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // pixel[7:0], period_elapsed[8]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // left_speed[8:0], right_speed[17:9], line_error[29:18]
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  line_position_pd_steering_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Steering predictor state.
  lpps_pkg::cfg_t   reg_mirror;
  logic [SUM_W-1:0] pos_sum [LINE_PX];
  int               pix_index;
  int               frame_index;
  longint           prev_err;
  longint           err_chg;
  steer_out_t       steer_q [$];

  logic [PIX_W-1:0] frame_px [LINE_PX];
  int               pixels_sent;
  int               results_checked;
  int               cfg_writes;
  int               mismatch_count;
  bit               gaps_on;
  int               burst_left;
  int               hold_req;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("line_position_pd_steering_core test failed");
    $finish;
  end

  function automatic longint limit_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_frames();
    int n;
    n = reg_mirror.frames_per_burst;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  // Accumulates one pixel and, on the pixel that closes a burst, queues the drive result.
  function automatic void steer_take_pixel(input logic [PIX_W-1:0] pix, input logic period);
    int         frames;
    longint     need;
    longint     err;
    longint     pd;
    longint     lim;
    longint     lft;
    longint     rgt;
    steer_out_t r;
    frames = eff_frames();
    pos_sum[pix_index] = pos_sum[pix_index] + pix;
    if (pix_index + 1 < LINE_PX) begin
      pix_index++;
      return;
    end
    pix_index = 0;
    if (frame_index + 1 < frames) begin
      frame_index++;
      return;
    end
    frame_index = 0;
    need = (longint'(reg_mirror.brightness_threshold) + 1) * frames;
    err = 0;
    for (int p = 0; p < LINE_PX; p++) begin
      if (longint'(pos_sum[p]) >= need) err += WEIGHT * (p - LINE_PX / 2);
    end
    err = limit_to(err, -2048, 2047);
    foreach (pos_sum[i]) pos_sum[i] = '0;
    if (period) begin
      err_chg  = limit_to(err - prev_err, -4096, 4095);
      prev_err = err;
    end
    lim = longint'(reg_mirror.speed_limit);
    pd  = longint'(reg_mirror.kp_q8) * err + longint'(reg_mirror.kd_rate_q8) * err_chg;
    lft = limit_to((longint'(reg_mirror.base_speed) * 256 + pd) / 256, -lim, lim);
    rgt = limit_to((longint'(reg_mirror.base_speed) * 256 - pd) / 256, -lim, lim);
    r.left_spd  = lft[SPD_W-1:0];
    r.right_spd = rgt[SPD_W-1:0];
    r.line_err  = err[ERR_W-1:0];
    steer_q.push_back(r);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  function automatic void fill_flat(input logic [PIX_W-1:0] v);
    foreach (frame_px[p]) frame_px[p] = v;
  endfunction

  function automatic void fill_line(input int center, input int width,
                                    input logic [PIX_W-1:0] hi, input logic [PIX_W-1:0] lo);
    foreach (frame_px[p]) frame_px[p] = (p >= center - width && p <= center + width) ? hi : lo;
  endfunction

  // Random upper bits above the register width; the block has to mask them off.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned v, input int w);
    logic [CFG_DATA_W-1:0] val;
    val = v[CFG_DATA_W-1:0];
    if ($urandom_range(0, 7) == 0 && w < CFG_DATA_W)
      val = val | (CFG_DATA_W'($urandom_range(0, 65535)) << w);
    return val;
  endfunction

  function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic period);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - PIX_W - 1){1'b0}}, period, pix};
    do @(posedge clk); while (in_tready !== 1'b1);
    pixels_sent++;
    steer_take_pixel(pix, period);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      lpps_pkg::REG_BASE_SPEED:   reg_mirror.base_speed           = val[7:0];
      lpps_pkg::REG_KP_Q8:        reg_mirror.kp_q8                = val[9:0];
      lpps_pkg::REG_KD_RATE_Q8:   reg_mirror.kd_rate_q8           = val[15:0];
      lpps_pkg::REG_BRIGHT_THR:   reg_mirror.brightness_threshold = val[7:0];
      lpps_pkg::REG_FRAMES_BURST: reg_mirror.frames_per_burst     = val[4:0];
      lpps_pkg::REG_SPEED_LIMIT:  reg_mirror.speed_limit          = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for every queued result, then for the snapshot scan to drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (LINE_PX + 8) @(posedge clk);
  endtask

  task automatic run_burst(input int frames_n, input frame_kind_t kind, input logic period);
    int               center;
    int               width;
    int               th;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    center = $urandom_range(0, LINE_PX - 1);
    width  = $urandom_range(0, 3);
    hi     = PIX_W'($urandom_range(140, 255));
    lo     = PIX_W'($urandom_range(0, 120));
    for (int f = 0; f < frames_n; f++) begin
      case (kind)
        FK_LINE:     fill_line(center + int'($urandom_range(0, 2)) - 1, width, hi, lo);
        FK_NOISE:    foreach (frame_px[p]) frame_px[p] = PIX_W'($urandom_range(0, 255));
        FK_NEAR_THR: begin
          foreach (frame_px[p]) begin
            th = int'(reg_mirror.brightness_threshold) + int'($urandom_range(0, 4)) - 2;
            frame_px[p] = (th < 0) ? 8'd0 : (th > 255) ? 8'd255 : th[7:0];
          end
        end
        FK_EXTREMES: foreach (frame_px[p]) frame_px[p] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: ;  // the caller has already filled the frame
      endcase
      for (int p = 0; p < LINE_PX; p++)
        send_pixel(frame_px[p], (f == frames_n - 1 && p == LINE_PX - 1) ?
                                period : logic'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_reset_defaults();
    // Ten frames with the line a little right of center, all registers at reset values.
    fill_line(21, 2, 8'd220, 8'd20);
    run_burst(10, FK_FIXED, 1'b1);
  endtask

  task automatic test_threshold_edges();
    settle();
    cfg_write(lpps_pkg::REG_FRAMES_BURST, 16'd0);
    cfg_write(lpps_pkg::REG_BRIGHT_THR, 16'd100);
    // An average equal to the threshold is not line, one above it is.
    fill_flat(8'd100);
    for (int p = 1; p < LINE_PX; p += 2) frame_px[p] = 8'd101;
    frame_px[0]           = 8'd0;
    frame_px[LINE_PX - 1] = 8'd255;
    run_burst(1, FK_FIXED, 1'b1);
    settle();
    cfg_write(lpps_pkg::REG_BRIGHT_THR, 16'd255);
    fill_flat(8'd255);
    run_burst(1, FK_FIXED, 1'b1);
    settle();
    cfg_write(lpps_pkg::REG_BRIGHT_THR, 16'd0);
    // Right half only gives the largest error, left half only the smallest.
    fill_line(LINE_PX - 1, LINE_PX / 2 - 1, 8'd1, 8'd0);
    run_burst(1, FK_FIXED, 1'b1);
    fill_line(0, LINE_PX / 2 - 1, 8'd1, 8'd0);
    run_burst(1, FK_FIXED, 1'b1);
  endtask

  task automatic test_period_flag();
    settle();
    cfg_write(lpps_pkg::REG_BRIGHT_THR, 16'd127);
    fill_line(28, 1, 8'd200, 8'd10);
    run_burst(1, FK_FIXED, 1'b1);
    // Without the period flag the previous error and the difference are kept.
    fill_line(4, 1, 8'd200, 8'd10);
    run_burst(1, FK_FIXED, 1'b0);
    fill_line(10, 0, 8'd200, 8'd10);
    run_burst(1, FK_FIXED, 1'b1);
  endtask

  task automatic test_gain_extremes();
    settle();
    cfg_write(lpps_pkg::REG_BASE_SPEED, 16'hFFFF);
    cfg_write(lpps_pkg::REG_KP_Q8, 16'hFFFF);
    cfg_write(lpps_pkg::REG_KD_RATE_Q8, 16'hFFFF);
    cfg_write(lpps_pkg::REG_SPEED_LIMIT, 16'h00FF);
    fill_flat(8'd255);
    run_burst(1, FK_FIXED, 1'b1);
    fill_line(LINE_PX - 1, 0, 8'd255, 8'd0);
    run_burst(1, FK_FIXED, 1'b1);
    settle();
    cfg_write(lpps_pkg::REG_SPEED_LIMIT, 16'hFF00);
    run_burst(1, FK_FIXED, 1'b1);
    settle();
    cfg_write(lpps_pkg::REG_SPEED_LIMIT, 16'd1);
    fill_line(3, 2, 8'd255, 8'd0);
    run_burst(1, FK_FIXED, 1'b1);
    settle();
    cfg_write(lpps_pkg::REG_BASE_SPEED, 16'd0);
    cfg_write(lpps_pkg::REG_KP_Q8, 16'd0);
    cfg_write(lpps_pkg::REG_KD_RATE_Q8, 16'd0);
    cfg_write(lpps_pkg::REG_SPEED_LIMIT, 16'd255);
    run_burst(1, FK_FIXED, 1'b0);
  endtask

  task automatic test_unused_registers();
    settle();
    cfg_write(lpps_pkg::REG_BASE_SPEED, 16'd100);
    cfg_write(lpps_pkg::REG_KP_Q8, 16'd200);
    cfg_write(lpps_pkg::REG_KD_RATE_Q8, 16'd3000);
    cfg_write(REG_UNUSED_LO, 16'hFFFF);
    cfg_write(REG_UNUSED_HI, 16'h0000);
    fill_line(22, 3, 8'd190, 8'd40);
    run_burst(1, FK_FIXED, 1'b1);
  endtask

  task automatic test_frame_count_limits();
    settle();
    // 17 after masking, which the block must treat as 16 frames.
    cfg_write(lpps_pkg::REG_FRAMES_BURST, 16'hFFF1);
    run_burst(eff_frames(), FK_LINE, 1'b1);
  endtask

  task automatic test_burst_cut_short();
    settle();
    cfg_write(lpps_pkg::REG_FRAMES_BURST, 16'd8);
    run_burst(3, FK_LINE, 1'b0);
    settle();
    // Three frames are in; with two per burst the next frame closes the burst.
    cfg_write(lpps_pkg::REG_FRAMES_BURST, 16'd2);
    run_burst(1, FK_LINE, 1'b1);
  endtask

  task automatic test_output_backpressure();
    settle();
    cfg_write(lpps_pkg::REG_FRAMES_BURST, 16'd1);
    cfg_write(lpps_pkg::REG_KD_RATE_Q8, 16'd5120);
    gaps_on  = 1'b0;
    hold_req = 400;
    for (int b = 0; b < 6; b++) run_burst(1, FK_LINE, logic'($urandom_range(0, 1)));
    gaps_on = 1'b1;
  endtask

  task automatic shuffle_registers();
    int unsigned r;
    int unsigned frames;
    if ($urandom_range(0, 1))
      cfg_write(lpps_pkg::REG_BASE_SPEED, with_junk(pick_value(0, 255), 8));
    if ($urandom_range(0, 1))
      cfg_write(lpps_pkg::REG_KP_Q8, with_junk(pick_value(0, 1023), 10));
    if ($urandom_range(0, 1))
      cfg_write(lpps_pkg::REG_KD_RATE_Q8, pick_value(0, 65535));
    if ($urandom_range(0, 1))
      cfg_write(lpps_pkg::REG_BRIGHT_THR, with_junk(pick_value(0, 255), 8));
    if ($urandom_range(0, 1))
      cfg_write(lpps_pkg::REG_SPEED_LIMIT, with_junk(pick_value(0, 255), 8));
    if ($urandom_range(0, 1)) begin
      // Short bursts dominate so that results stay frequent.
      r = $urandom_range(0, 99);
      if (r < 55)      frames = $urandom_range(1, 2);
      else if (r < 85) frames = $urandom_range(3, 4);
      else if (r < 95) frames = $urandom_range(5, 8);
      else if (r < 97) frames = 0;
      else if (r < 99) frames = $urandom_range(9, 16);
      else             frames = $urandom_range(17, 31);
      cfg_write(lpps_pkg::REG_FRAMES_BURST, with_junk(frames, 5));
    end
  endtask

  task automatic test_random_traffic();
    int nb;
    while (pixels_sent < TOTAL_ITEMS) begin
      settle();
      shuffle_registers();
      gaps_on = ($urandom_range(0, 3) != 0);
      nb = $urandom_range(1, 4);
      for (int b = 0; b < nb && pixels_sent < TOTAL_ITEMS; b++) begin
        run_burst(eff_frames(), frame_kind_t'($urandom_range(FK_LINE, FK_EXTREMES)),
                  logic'($urandom_range(0, 1)));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: changes its stall style every so often and honors long hold-off requests.
  initial begin : receiver
    stall_style_t style;
    int           style_left;
    int           hold_left;
    style      = RX_ALWAYS;
    style_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(RX_ALWAYS, RX_SELDOM));
        style_left = $urandom_range(16, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_result
    steer_out_t got;
    steer_out_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.left_spd  = out_tdata[8:0];
      got.right_spd = out_tdata[17:9];
      got.line_err  = out_tdata[29:18];
      if (steer_q.size() == 0) begin
        note_mismatch($sformatf("result with no burst pending: left %0d right %0d error %0d",
                                got.left_spd, got.right_spd, got.line_err));
      end else begin
        want = steer_q.pop_front();
        results_checked++;
        if (got.left_spd !== want.left_spd)
          note_mismatch($sformatf("left_speed expected %0d, got %0d",
                                  want.left_spd, got.left_spd));
        if (got.right_spd !== want.right_spd)
          note_mismatch($sformatf("right_speed expected %0d, got %0d",
                                  want.right_spd, got.right_spd));
        if (got.line_err !== want.line_err)
          note_mismatch($sformatf("line_error expected %0d, got %0d",
                                  want.line_err, got.line_err));
      end
    end
  end

  initial begin
    reg_mirror = '{base_speed: lpps_pkg::BASE_SPEED_RST,
                   kp_q8: lpps_pkg::KP_Q8_RST,
                   kd_rate_q8: lpps_pkg::KD_RATE_Q8_RST,
                   brightness_threshold: lpps_pkg::BRIGHT_THR_RST,
                   frames_per_burst: lpps_pkg::FRAMES_BURST_RST,
                   speed_limit: lpps_pkg::SPEED_LIMIT_RST};
    foreach (pos_sum[i]) pos_sum[i] = '0;
    pix_index       = 0;
    frame_index     = 0;
    prev_err        = 0;
    err_chg         = 0;
    pixels_sent     = 0;
    results_checked = 0;
    cfg_writes      = 0;
    mismatch_count  = 0;
    gaps_on         = 1'b1;
    burst_left      = 0;
    hold_req        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_edges();
    test_period_flag();
    test_gain_extremes();
    test_unused_registers();
    test_frame_count_limits();
    test_burst_cut_short();
    test_output_backpressure();
    test_random_traffic();
    settle();

    $display("Run summary: %0d pixels sent, %0d steering results checked, %0d register writes.",
             pixels_sent, results_checked, cfg_writes);
    $display("Covered defaults, threshold edges, frame count limits, gain extremes, ",
             "a long output stall and random bursts.");
    if (mismatch_count == 0 && steer_q.size() == 0) begin
      $display("line_position_pd_steering_core test passed");
    end else begin
      $display("line_position_pd_steering_core test failed");
    end
    $finish;
  end

endmodule
